FILE: rtl/core/arcc_pkg.sv
`timescale 1ns / 1ps
// arcc_pkg: shared types, constants and helper functions for aes_round_code_check
// holds the s-box and crc32c column tables built at elaboration, and the reference rom
// depends on nothing
package arcc_pkg;

  localparam int unsigned CHECK_BLOCKS_DEF = 4;
  localparam int unsigned ROM_BYTES        = 'h40;
  localparam int unsigned BLOCK_BYTES      = 'h10;
  localparam int unsigned ROM_BLOCKS       = ROM_BYTES / BLOCK_BYTES;
  localparam int unsigned BLOCK_W          = 8 * BLOCK_BYTES;
  localparam int unsigned REG_W            = 32;

  localparam logic [REG_W-1:0] CRC32C_POLY   = 32'h82F6_3B78;
  localparam logic [REG_W-1:0] KEY_SEED_A_RST = 32'hBB40_E64D;
  localparam logic [REG_W-1:0] KEY_SEED_B_RST = 32'hA205_B064;
  localparam logic [REG_W-1:0] NAME_LOW_RST   = 32'h3053_306D;
  localparam logic [REG_W-1:0] NAME_HIGH_RST  = 32'h3059_3067;

  typedef enum logic [1:0] {
    REG_KEY_SEED_A = 2'd0,
    REG_KEY_SEED_B = 2'd1,
    REG_NAME_LOW   = 2'd2,
    REG_NAME_HIGH  = 2'd3
  } cfg_reg_e;

  typedef logic [7:0]         sbox_t     [256];
  typedef logic [REG_W-1:0]   crc_cols_t [REG_W];
  typedef logic [BLOCK_W-1:0] rom_t      [ROM_BLOCKS];

  // byte i of a block sits at bits [8i +: 8]
  localparam rom_t REF_ROM = '{
    128'hbd84_76bf_0b2d_a325_3cd3_9b48_018f_d736,
    128'ha853_eccd_6438_dde7_7118_aff4_2852_e986,
    128'hd9fd_19cc_1280_d939_e05e_1365_185f_8c56,
    128'hb8bb_3bbc_9c74_1ba3_3a74_abb5_bc8b_b67c
  };

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) r = r ^ x;
      x = xtime(x);
    end
    return r;
  endfunction

  function automatic logic [7:0] sbox_calc(logic [7:0] a);
    logic [7:0] inv;
    logic [7:0] base;
    logic [7:0] e;
    inv  = 8'h01;
    base = a;
    e    = 8'd254;
    for (int k = 0; k < 8; k++) begin
      if (e[k]) inv = gf_mul(inv, base);
      base = gf_mul(base, base);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic sbox_t build_sbox();
    sbox_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = sbox_calc(8'(i));
    end
    return t;
  endfunction

  localparam sbox_t SBOX = build_sbox();

  // response of the 32-step reflected crc to each single input bit
  function automatic crc_cols_t build_crc_cols();
    crc_cols_t  t;
    logic [REG_W-1:0] c;
    for (int i = 0; i < REG_W; i++) begin
      c = REG_W'(1) << i;
      for (int b = 0; b < REG_W; b++) begin
        c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_cols_t CRC_COLS = build_crc_cols();

  // crc is linear over gf(2), so the word crc is an xor of precomputed columns
  function automatic logic [REG_W-1:0] crc32c_word(logic [REG_W-1:0] seed,
                                                   logic [REG_W-1:0] data);
    logic [REG_W-1:0] v;
    logic [REG_W-1:0] r;
    v = seed ^ data;
    r = '0;
    for (int i = 0; i < REG_W; i++) begin
      if (v[i]) r = r ^ CRC_COLS[i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/arcc_block_if.sv
`timescale 1ns / 1ps
// arcc_block_if: input channel carrying one 16-byte code block per transaction
// depends on nothing
interface arcc_block_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_low;
  logic [63:0] block_high;

  modport source (output valid, output block_low, output block_high, input ready);
  modport sink   (input valid, input block_low, input block_high, output ready);
endinterface

FILE: rtl/core/arcc_result_if.sv
`timescale 1ns / 1ps
// arcc_result_if: output channel carrying one round result per transaction
// depends on nothing
interface arcc_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_low;
  logic [63:0] cipher_high;
  logic        final_block;
  logic        code_matched;

  modport source (output valid, output cipher_low, output cipher_high,
                  output final_block, output code_matched, input ready);
  modport sink   (input valid, input cipher_low, input cipher_high,
                  input final_block, input code_matched, output ready);
endinterface

FILE: rtl/core/aes_round_code_check.sv
`timescale 1ns / 1ps
// aes_round_code_check: one aes encryption round per block, checked against a reference rom
// depends on arcc_pkg, arcc_block_if and arcc_result_if
//
// Usage
//   blk_i carries one 16-byte block per transaction, res_o returns one result per block
//   in the same order: the round output, a flag on the last block of a check and, on that
//   block, whether every block of the check equalled the reference rom.
//   The round key comes from four crc32c values over the configuration registers; the
//   key is refreshed from the registers every cycle, so a write counts from the next block.
//   cfg_we_i writes cfg_wdata_i into register cfg_idx_i; write only while no block is in
//   flight.
//   An accepted block passes the input register, then the result register, and res_o
//   shows it from there; blk_i takes one block per cycle while results are taken, and
//   shiftrows, s-box lookup, mixcolumns and key xor sit between the two registers.
//   A stalled receiver holds the result register; the input register keeps taking one
//   more block, then blk_i.ready drops until the result is taken.
//   Reset clears both valid flags, the block counter and the mismatch flag, and loads the
//   register reset values.
module aes_round_code_check
  import arcc_pkg::*;
#(
  parameter int unsigned CHECK_BLOCKS = CHECK_BLOCKS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [REG_W-1:0] cfg_wdata_i,
  arcc_block_if.sink       blk_i,
  arcc_result_if.source    res_o
);

  localparam int unsigned CNT_W = (CHECK_BLOCKS > 1) ? $clog2(CHECK_BLOCKS) : 1;

  logic [REG_W-1:0]   seed_a_q, seed_b_q, name_low_q, name_high_q;
  logic [BLOCK_W-1:0] key_q;
  logic               s1_valid_q;
  logic [BLOCK_W-1:0] blk_q;
  logic               out_valid_q;
  logic [BLOCK_W-1:0] cipher_q;
  logic               final_q;
  logic               matched_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               mismatch_q, mismatch_d;

  logic               s2_adv;
  logic               blk_acc;
  logic [BLOCK_W-1:0] sh;
  logic [BLOCK_W-1:0] res_d;
  logic [3:0]         cnt_ext;
  logic               in_rom;
  logic               cur_mis;
  logic               last;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_a_q    <= KEY_SEED_A_RST;
      seed_b_q    <= KEY_SEED_B_RST;
      name_low_q  <= NAME_LOW_RST;
      name_high_q <= NAME_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_SEED_A: seed_a_q    <= cfg_wdata_i;
        REG_KEY_SEED_B: seed_b_q    <= cfg_wdata_i;
        REG_NAME_LOW:   name_low_q  <= cfg_wdata_i;
        REG_NAME_HIGH:  name_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // round key, the crc of seed b over name high in the low bits
  always_ff @(posedge clk_i) begin
    key_q <= {crc32c_word(seed_a_q, name_low_q), crc32c_word(seed_a_q, name_high_q),
              crc32c_word(seed_b_q, name_low_q), crc32c_word(seed_b_q, name_high_q)};
  end

  assign s2_adv      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign blk_i.ready = !s1_valid_q || s2_adv;
  assign blk_acc     = blk_i.valid && blk_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (blk_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s2_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_acc) begin
      blk_q <= {blk_i.block_high, blk_i.block_low};
    end
  end

  // shiftrows then subbytes, byte index = row + 4 * column
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sh[8*(r+4*c) +: 8] = SBOX[blk_q[8*(r + 4*((c + r) % 4)) +: 8]];
      end
    end
  end

  // mixcolumns and key addition
  always_comb begin
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = sh[32*c +: 8];
      a1 = sh[32*c + 8 +: 8];
      a2 = sh[32*c + 16 +: 8];
      a3 = sh[32*c + 24 +: 8];
      res_d[32*c +: 8]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      res_d[32*c + 8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      res_d[32*c + 16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      res_d[32*c + 24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    res_d = res_d ^ key_q;
  end

  // blocks past the rom count as matching
  assign cnt_ext = 4'(cnt_q);
  assign in_rom  = (cnt_ext[3:2] == 2'b00);
  assign cur_mis = in_rom && (res_d != REF_ROM[cnt_ext[1:0]]);
  assign last    = (cnt_q == CNT_W'(CHECK_BLOCKS - 1));

  always_comb begin
    cnt_d      = cnt_q;
    mismatch_d = mismatch_q;
    if (s2_adv) begin
      if (last) begin
        cnt_d      = '0;
        mismatch_d = 1'b0;
      end else begin
        cnt_d      = cnt_q + CNT_W'(1);
        mismatch_d = mismatch_q || cur_mis;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      mismatch_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      mismatch_q <= mismatch_d;
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      cipher_q  <= res_d;
      final_q   <= last;
      matched_q <= last && !(mismatch_q || cur_mis);
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.cipher_low   = cipher_q[63:0];
  assign res_o.cipher_high  = cipher_q[127:64];
  assign res_o.final_block  = final_q;
  assign res_o.code_matched = matched_q;

`ifndef SYNTHESIS
  a_cnt_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_adv && last |=> cnt_q == '0 && !mismatch_q)
    else $error("block counter did not restart after the last block");

  a_match_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && matched_q |-> final_q)
    else $error("code_matched raised on a non-final block");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_adv |=> s1_valid_q && $stable(blk_q))
    else $error("input register lost a stalled block");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    5'(cnt_q) < 5'(CHECK_BLOCKS))
    else $error("block counter beyond the check length");
`endif

endmodule

FILE: tb/arcc_tb_pkg.sv
`timescale 1ns / 1ps
// arcc_tb_pkg: round arithmetic, key derivation and the expected code rom for the testbench
// shared by the checker (forward round) and the stimulus (inverse round); depends on nothing
package arcc_tb_pkg;

  typedef logic [7:0] byte_tab_t [256];

  localparam logic [31:0] CASTAGNOLI_REFL = 32'h82F6_3B78;

  localparam logic [7:0] CODE_ROM [64] = '{
    8'h36, 8'hd7, 8'h8f, 8'h01, 8'h48, 8'h9b, 8'hd3, 8'h3c,
    8'h25, 8'ha3, 8'h2d, 8'h0b, 8'hbf, 8'h76, 8'h84, 8'hbd,
    8'h86, 8'he9, 8'h52, 8'h28, 8'hf4, 8'haf, 8'h18, 8'h71,
    8'he7, 8'hdd, 8'h38, 8'h64, 8'hcd, 8'hec, 8'h53, 8'ha8,
    8'h56, 8'h8c, 8'h5f, 8'h18, 8'h65, 8'h13, 8'h5e, 8'he0,
    8'h39, 8'hd9, 8'h80, 8'h12, 8'hcc, 8'h19, 8'hfd, 8'hd9,
    8'h7c, 8'hb6, 8'h8b, 8'hbc, 8'hb5, 8'hab, 8'h74, 8'h3a,
    8'ha3, 8'h1b, 8'h74, 8'h9c, 8'hbc, 8'h3b, 8'hbb, 8'hb8
  };

  function automatic logic [7:0] xt(logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ 8'h1B) : {a[6:0], 1'b0};
  endfunction

  // horner form, msb of the multiplier first
  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int k = 7; k >= 0; k--) begin
      p = xt(p);
      if (b[k]) p = p ^ a;
    end
    return p;
  endfunction

  // inverse through power and log tables of the generator 3, then the affine map
  function automatic byte_tab_t build_sub_table();
    byte_tab_t   t;
    logic [7:0]  pw [255];
    int unsigned lg [256];
    logic [7:0]  g;
    logic [7:0]  inv;
    logic [7:0]  rot;
    g = 8'h01;
    lg[0] = 0;
    for (int i = 0; i < 255; i++) begin
      pw[i] = g;
      lg[g] = i;
      g = g ^ xt(g);
    end
    for (int v = 0; v < 256; v++) begin
      inv = (v == 0) ? 8'h00 : pw[(255 - lg[v]) % 255];
      t[v] = inv ^ 8'h63;
      rot = inv;
      for (int k = 0; k < 4; k++) begin
        rot = {rot[6:0], rot[7]};
        t[v] = t[v] ^ rot;
      end
    end
    return t;
  endfunction

  function automatic byte_tab_t invert_table(byte_tab_t f);
    byte_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[f[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam byte_tab_t SUB_TAB     = build_sub_table();
  localparam byte_tab_t INV_SUB_TAB = invert_table(SUB_TAB);

  function automatic logic [31:0] crc_castagnoli(logic [31:0] seed, logic [31:0] data);
    logic [31:0] c;
    c = seed ^ data;
    for (int b = 0; b < 32; b++) begin
      c = c[0] ? ((c >> 1) ^ CASTAGNOLI_REFL) : (c >> 1);
    end
    return c;
  endfunction

  // the crc of seed_b over name_hi sits in the low bits; byte i of the key is at [8i +: 8]
  function automatic logic [127:0] round_key(logic [31:0] seed_a, logic [31:0] seed_b,
                                             logic [31:0] name_lo, logic [31:0] name_hi);
    return {crc_castagnoli(seed_a, name_lo), crc_castagnoli(seed_a, name_hi),
            crc_castagnoli(seed_b, name_lo), crc_castagnoli(seed_b, name_hi)};
  endfunction

  function automatic logic [127:0] rom_block(int unsigned idx);
    logic [127:0] b;
    for (int i = 0; i < 16; i++) begin
      b[8*i +: 8] = CODE_ROM[16*idx + i];
    end
    return b;
  endfunction

  // byte index = row + 4 * column
  function automatic logic [127:0] aes_round(logic [127:0] state, logic [127:0] key);
    logic [7:0]   s [16];
    logic [127:0] mixed;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        s[r + 4*c] = SUB_TAB[state[8*(r + 4*((c + r) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = s[4*c];
      a1 = s[4*c + 1];
      a2 = s[4*c + 2];
      a3 = s[4*c + 3];
      mixed[8*(4*c)     +: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      mixed[8*(4*c + 1) +: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      mixed[8*(4*c + 2) +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      mixed[8*(4*c + 3) +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return mixed ^ key;
  endfunction

endpackage

FILE: tb/aes_round_code_check_chk.sv
`timescale 1ns / 1ps
// aes_round_code_check_chk: watches the block, result and configuration ports, predicts
// each round result and compares it; depends on arcc_pkg, arcc_tb_pkg and both channels
module aes_round_code_check_chk
  import arcc_pkg::*;
  import arcc_tb_pkg::*;
#(
  parameter int unsigned CHECK_LEN = CHECK_BLOCKS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [REG_W-1:0] cfg_wdata_i,
  arcc_block_if            blk_i,
  arcc_result_if           res_i,
  output int               fail_cnt_o,
  output int               outstanding_o
);

  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [63:0] cipher_low;
    logic [63:0] cipher_high;
    logic        final_block;
    logic        code_matched;
  } round_out_t;

  round_out_t  expected_rounds [$];
  round_out_t  want;
  logic [31:0] seed_a, seed_b, name_lo, name_hi;
  int unsigned blk_pos;
  logic        diverged;
  int unsigned results_seen;

  task automatic note_mismatch(string msg);
    if (fail_cnt_o < MAX_PRINTS) $display("%0t mismatch: %s", $time, msg);
    fail_cnt_o++;
  endtask

  task automatic cmp_field(string field, logic [63:0] got, logic [63:0] want_v);
    if (got !== want_v) begin
      note_mismatch($sformatf("result %0d %s: got %h, want %h",
                              results_seen, field, got, want_v));
    end
  endtask

  function automatic round_out_t predict_round(logic [127:0] code);
    round_out_t   o;
    logic [127:0] cipher;
    logic         last;
    cipher = aes_round(code, round_key(seed_a, seed_b, name_lo, name_hi));
    // positions beyond the rom count as matching
    if (blk_pos < ROM_BLOCKS && cipher != rom_block(blk_pos)) diverged = 1'b1;
    last = (blk_pos + 1 >= CHECK_LEN);
    o.cipher_low   = cipher[63:0];
    o.cipher_high  = cipher[127:64];
    o.final_block  = last;
    o.code_matched = last && !diverged;
    if (last) begin
      blk_pos  = 0;
      diverged = 1'b0;
    end else begin
      blk_pos++;
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_a        = KEY_SEED_A_RST;
      seed_b        = KEY_SEED_B_RST;
      name_lo       = NAME_LOW_RST;
      name_hi       = NAME_HIGH_RST;
      blk_pos       = 0;
      diverged      = 1'b0;
      results_seen  = 0;
      fail_cnt_o    = 0;
      expected_rounds.delete();
      outstanding_o = 0;
    end else begin
      // a transaction in takes the registers as they were before this edge
      if (blk_i.valid && blk_i.ready) begin
        expected_rounds.push_back(predict_round({blk_i.block_high, blk_i.block_low}));
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_rounds.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
        end else begin
          want = expected_rounds.pop_front();
          cmp_field("cipher_low", res_i.cipher_low, want.cipher_low);
          cmp_field("cipher_high", res_i.cipher_high, want.cipher_high);
          cmp_field("final_block", 64'(res_i.final_block), 64'(want.final_block));
          cmp_field("code_matched", 64'(res_i.code_matched), 64'(want.code_matched));
        end
        results_seen++;
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_KEY_SEED_A: seed_a  = cfg_wdata_i;
          REG_KEY_SEED_B: seed_b  = cfg_wdata_i;
          REG_NAME_LOW:   name_lo = cfg_wdata_i;
          REG_NAME_HIGH:  name_hi = cfg_wdata_i;
          default: ;
        endcase
      end
      outstanding_o = expected_rounds.size();
    end
  end

endmodule

FILE: tb/aes_round_code_check_tb.sv
`timescale 1ns / 1ps
// aes_round_code_check_tb: drives code blocks and register settings into the block and
// gives the verdict; depends on arcc_pkg, arcc_tb_pkg, both channels and the checker
module aes_round_code_check_tb;
  import arcc_pkg::*;
  import arcc_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 100000;
  localparam int unsigned PHASES           = 8;
  localparam int unsigned CHECKS_PER_PHASE = 42;
  localparam int unsigned SETTLE_CYCLES    = 8;

  typedef enum int {
    CK_GOOD,
    CK_ONE_BAD,
    CK_NOISE
  } check_kind_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  cfg_reg_e    cfg_idx_i   = REG_KEY_SEED_A;
  logic [31:0] cfg_wdata_i = '0;

  int          fail_cnt;
  int          outstanding;
  int unsigned cycle_cnt   = 0;
  int unsigned blocks_sent = 0;
  bit          idle_on     = 1'b1;
  logic [31:0] shadow [4]  = '{KEY_SEED_A_RST, KEY_SEED_B_RST, NAME_LOW_RST, NAME_HIGH_RST};

  arcc_block_if  blk_if ();
  arcc_result_if res_if ();

  aes_round_code_check dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i,
    .blk_i (blk_if),
    .res_o (res_if)
  );

  aes_round_code_check_chk chk (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i,
    .blk_i         (blk_if),
    .res_i         (res_if),
    .fail_cnt_o    (fail_cnt),
    .outstanding_o (outstanding)
  );

  always #1 clk_i = ~clk_i;

  // block that the round turns into rom block pos under the current key
  function automatic logic [127:0] code_for(int unsigned pos);
    logic [127:0] t;
    logic [127:0] code;
    logic [7:0]   a0, a1, a2, a3;
    logic [7:0]   unmixed [16];
    t = rom_block(pos) ^ round_key(shadow[REG_KEY_SEED_A], shadow[REG_KEY_SEED_B],
                                   shadow[REG_NAME_LOW], shadow[REG_NAME_HIGH]);
    for (int c = 0; c < 4; c++) begin
      a0 = t[8*(4*c)     +: 8];
      a1 = t[8*(4*c + 1) +: 8];
      a2 = t[8*(4*c + 2) +: 8];
      a3 = t[8*(4*c + 3) +: 8];
      unmixed[4*c]     = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
      unmixed[4*c + 1] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
      unmixed[4*c + 2] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
      unmixed[4*c + 3] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        code[8*(r + 4*((c + r) % 4)) +: 8] = INV_SUB_TAB[unmixed[r + 4*c]];
      end
    end
    return code;
  endfunction

  // entered and left at a falling edge; valid stays high when the next block follows
  task automatic send_block(input logic [127:0] code);
    while (idle_on && $urandom_range(99) < 33) begin
      blk_if.valid = 1'b0;
      @(negedge clk_i);
    end
    blk_if.block_low  = code[63:0];
    blk_if.block_high = code[127:64];
    blk_if.valid      = 1'b1;
    @(posedge clk_i);
    while (!blk_if.ready) @(posedge clk_i);
    blocks_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_check(check_kind_e kind, int unsigned bad_at);
    logic [127:0] code;
    int unsigned  flip_bit;
    for (int k = 0; k < CHECK_BLOCKS_DEF; k++) begin
      if (kind == CK_NOISE) begin
        code = {$urandom, $urandom, $urandom, $urandom};
      end else begin
        code = code_for(blocks_sent % CHECK_BLOCKS_DEF);
        if (kind == CK_ONE_BAD && k == bad_at) begin
          flip_bit = $urandom_range(127);
          code[flip_bit] = ~code[flip_bit];
        end
      end
      send_block(code);
    end
  endtask

  task automatic drain();
    blk_if.valid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] v);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = v;
    shadow[idx] = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      res_if.ready = !(idle_on && $urandom_range(99) < 33);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    cfg_reg_e    r;
    logic [31:0] vals [4];
    logic [3:0]  wr_mask;
    int unsigned pick;
    blk_if.valid      = 1'b0;
    blk_if.block_low  = '0;
    blk_if.block_high = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: clean check, extremes, bad first and last block, 55AA/AA55, rom 2-3
    run_check(CK_GOOD, 0);
    send_block('0);
    send_block('1);
    send_block({64'h0, 64'hFFFF_FFFF_FFFF_FFFF});
    send_block({64'hFFFF_FFFF_FFFF_FFFF, 64'h0});
    run_check(CK_ONE_BAD, 0);
    run_check(CK_ONE_BAD, CHECK_BLOCKS_DEF - 1);
    send_block({4{32'h55AA_55AA}});
    send_block({4{32'hAA55_AA55}});
    send_block(code_for(2));
    send_block(code_for(3));

    for (int ph = 0; ph < PHASES; ph++) begin
      wr_mask = 4'hF;
      case (ph)
        0: wr_mask = 4'h0;
        1: vals = '{32'h0, 32'h0, 32'h0, 32'h0};
        2: vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        3: vals = '{$urandom, $urandom, $urandom, $urandom};
        4: vals = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
        5: begin
          vals    = '{$urandom, $urandom, $urandom, $urandom};
          wr_mask = 4'($urandom);
        end
        6: vals = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF};
        default: vals = '{KEY_SEED_A_RST, KEY_SEED_B_RST, NAME_LOW_RST, NAME_HIGH_RST};
      endcase
      if (wr_mask != 4'h0) begin
        drain();
        r = r.first();
        do begin
          if (wr_mask[r]) write_reg(r, vals[r]);
          r = r.next();
        end while (r != r.first());
      end
      // one phase runs flat out on both sides
      idle_on = (ph != 3);
      for (int n = 0; n < CHECKS_PER_PHASE; n++) begin
        if (ph == 5 && n == CHECKS_PER_PHASE / 2) drain();
        pick = $urandom_range(99);
        if (pick < 60) run_check(CK_GOOD, 0);
        else if (pick < 85) run_check(CK_ONE_BAD, $urandom_range(CHECK_BLOCKS_DEF - 1));
        else run_check(CK_NOISE, 0);
      end
    end

    blk_if.valid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
